### sv/i8pool_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8pool_pkg
// Shared constants, register indexes and controller/datapath link types.
// ----------------------------------------------------------------------------
package i8pool_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int MAX_WINDOW = 16;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int LINE_W = $clog2(MAX_WINDOW);
  localparam int WIN_W  = $clog2(MAX_WINDOW) + 1;
  localparam int DIM_W  = 11;
  localparam int GEO_W  = 13;
  localparam int CFG_W  = 11;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_POOL_MODE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_ROWS  = 3'd1;
  localparam logic [IDX_W-1:0] REG_IMAGE_COLS  = 3'd2;
  localparam logic [IDX_W-1:0] REG_WINDOW_ROWS = 3'd3;
  localparam logic [IDX_W-1:0] REG_WINDOW_COLS = 3'd4;
  localparam logic [IDX_W-1:0] REG_STEP_SIZE   = 3'd5;

  localparam logic MODE_MAX = 1'b0;
  localparam logic MODE_AVG = 1'b1;

  typedef struct packed {
    logic              wr_en;
    logic [LINE_W-1:0] wr_line;
    logic [COL_W-1:0]  wr_col;
    logic              start;
    logic              mode;
    logic [WIN_W-1:0]  win_rows;
    logic [WIN_W-1:0]  win_cols;
    logic [ROW_W-1:0]  res_row;
    logic [COL_W-1:0]  res_col;
    logic              res_last;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } sts_t;

endpackage

### sv/int8_pooling_2d_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_pooling_2d_top
// Streaming 2-D max or average pooling of a signed 8-bit image.
// ----------------------------------------------------------------------------
// Pixels enter one beat at a time in row-major order and land in a line store
// of the last 16 rows. A pixel that completes no window is taken without a stall.
// A pixel that completes a window holds the input while the window is read
// from the store one pixel a cycle, then in average mode while the bit-serial
// divider runs, and until the output register is free to take the result.
// The result sits in that register, so the input runs on while it waits for
// the receiver; a second result stalls the input until the first has gone.
// Geometry writes restart the frame; the line store needs no clearing.
module int8_pooling_2d_top import i8pool_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // pixel
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,  // pooled, out_row, out_col, zero fill
  output logic             out_tlast   // frame_done
);

  cmd_t cmd;
  sts_t sts;

  i8pool_ctrl u_ctrl (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_wdata,
    .in_tvalid, .in_tready, .cmd, .sts
  );

  i8pool_dp u_dp (
    .clk, .rst_n, .pixel(in_tdata), .cmd, .sts,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

endmodule

### sv/i8pool_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8pool_ctrl
// Configuration registers, frame counters and window completion control.
// ----------------------------------------------------------------------------
module i8pool_ctrl import i8pool_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  output cmd_t             cmd,
  input  sts_t             sts
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic state_r, state_nxt;
  logic             mode_r;
  logic [DIM_W-1:0] img_rows_r, img_cols_r;
  logic [4:0]       win_rows_r, win_cols_r, step_r;

  logic [ROW_W-1:0] prow_r, prow_nxt;
  logic [COL_W-1:0] pcol_r, pcol_nxt;
  logic [ROW_W-1:0] nwr_r, nwr_nxt;
  logic [COL_W-1:0] nwc_r, nwc_nxt;
  logic [GEO_W-1:0] orow_r, orow_nxt, ocol_r, ocol_nxt;
  logic [GEO_W-1:0] rmul_r, rmul_nxt, cmul_r, cmul_nxt;

  logic [GEO_W-1:0] rows, cols, wr, wc, st;
  logic row_ends, col_ends, fire, last_row, last_col, accept, restart;

  always_comb begin
    rows = (img_rows_r == '0) ? GEO_W'(1) :
           (img_rows_r > DIM_W'(MAX_ROWS)) ? GEO_W'(MAX_ROWS) : GEO_W'(img_rows_r);
    cols = (img_cols_r == '0) ? GEO_W'(1) :
           (img_cols_r > DIM_W'(MAX_COLS)) ? GEO_W'(MAX_COLS) : GEO_W'(img_cols_r);
    wr = (win_rows_r == '0) ? GEO_W'(1) :
         (win_rows_r > 5'(MAX_WINDOW)) ? GEO_W'(MAX_WINDOW) : GEO_W'(win_rows_r);
    wc = (win_cols_r == '0) ? GEO_W'(1) :
         (win_cols_r > 5'(MAX_WINDOW)) ? GEO_W'(MAX_WINDOW) : GEO_W'(win_cols_r);
    st = (step_r == '0) ? GEO_W'(1) :
         (step_r > 5'(MAX_WINDOW)) ? GEO_W'(MAX_WINDOW) : GEO_W'(step_r);
  end

  assign row_ends = (orow_r + wr - GEO_W'(1) == GEO_W'(prow_r)) && (rmul_r + wr <= rows);
  assign col_ends = (ocol_r + wc - GEO_W'(1) == GEO_W'(pcol_r)) && (cmul_r + wc <= cols);
  assign last_row = (orow_r + st + wr > rows) || (rmul_r + wr + wr > rows);
  assign last_col = (ocol_r + st + wc > cols) || (cmul_r + wc + wc > cols);

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign fire      = accept && row_ends && col_ends;
  assign restart   = cfg_wr_en && (cfg_index != REG_POOL_MODE) && (cfg_index <= REG_STEP_SIZE);

  always_comb begin
    cmd.wr_en    = accept;
    cmd.wr_line  = prow_r[LINE_W-1:0];
    cmd.wr_col   = pcol_r;
    cmd.start    = fire;
    cmd.mode     = mode_r;
    cmd.win_rows = wr[WIN_W-1:0];
    cmd.win_cols = wc[WIN_W-1:0];
    cmd.res_row  = nwr_r;
    cmd.res_col  = nwc_r;
    cmd.res_last = last_row && last_col;
  end

  always_comb begin
    state_nxt = state_r;
    prow_nxt = prow_r; pcol_nxt = pcol_r;
    nwr_nxt = nwr_r; nwc_nxt = nwc_r;
    orow_nxt = orow_r; ocol_nxt = ocol_r;
    rmul_nxt = rmul_r; cmul_nxt = cmul_r;
    case (state_r)
      ST_IDLE: if (fire) state_nxt = ST_BUSY;
      ST_BUSY: if (!sts.busy) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    if (accept) begin
      if (fire) begin
        nwc_nxt  = nwc_r + COL_W'(1);
        ocol_nxt = ocol_r + st;
        cmul_nxt = cmul_r + wc;
      end
      if (GEO_W'(pcol_r) + GEO_W'(1) >= cols) begin
        pcol_nxt = '0; nwc_nxt = '0; ocol_nxt = '0; cmul_nxt = '0;
        if (row_ends) begin
          nwr_nxt  = nwr_r + ROW_W'(1);
          orow_nxt = orow_r + st;
          rmul_nxt = rmul_r + wr;
        end
        prow_nxt = prow_r + ROW_W'(1);
        if (GEO_W'(prow_r) + GEO_W'(1) >= rows) begin
          prow_nxt = '0; nwr_nxt = '0; orow_nxt = '0; rmul_nxt = '0;
        end
      end else begin
        pcol_nxt = pcol_r + COL_W'(1);
      end
    end
    if (restart) begin
      prow_nxt = '0; pcol_nxt = '0; nwr_nxt = '0; nwc_nxt = '0;
      orow_nxt = '0; ocol_nxt = '0; rmul_nxt = '0; cmul_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r <= MODE_MAX;
      img_rows_r <= DIM_W'(1024);
      img_cols_r <= DIM_W'(1024);
      win_rows_r <= 5'd2;
      win_cols_r <= 5'd2;
      step_r <= 5'd2;
      prow_r <= '0; pcol_r <= '0; nwr_r <= '0; nwc_r <= '0;
      orow_r <= '0; ocol_r <= '0; rmul_r <= '0; cmul_r <= '0;
    end else begin
      state_r <= state_nxt;
      prow_r <= prow_nxt; pcol_r <= pcol_nxt;
      nwr_r <= nwr_nxt; nwc_r <= nwc_nxt;
      orow_r <= orow_nxt; ocol_r <= ocol_nxt;
      rmul_r <= rmul_nxt; cmul_r <= cmul_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_POOL_MODE:   mode_r <= cfg_wdata[0];
          REG_IMAGE_ROWS:  img_rows_r <= cfg_wdata;
          REG_IMAGE_COLS:  img_cols_r <= cfg_wdata;
          REG_WINDOW_ROWS: win_rows_r <= cfg_wdata[4:0];
          REG_WINDOW_COLS: win_cols_r <= cfg_wdata[4:0];
          REG_STEP_SIZE:   step_r <= cfg_wdata[4:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### sv/i8pool_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8pool_dp
// Line store, window walk, max/sum accumulation, divider and output register.
// ----------------------------------------------------------------------------
module i8pool_dp import i8pool_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  pixel,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic        out_tlast
);

  localparam int ADDR_W = LINE_W + COL_W;
  localparam int DEPTH  = MAX_WINDOW * MAX_COLS;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_WALK  = 3'd1;
  localparam logic [2:0] PH_DRAIN = 3'd2;
  localparam logic [2:0] PH_DIV   = 3'd3;
  localparam logic [2:0] PH_LOAD  = 3'd4;

  logic [7:0] mem [0:DEPTH-1];
  logic [7:0] rdata_r;

  logic [2:0]        ph_r;
  logic              mode_r, last_r;
  logic [WIN_W-1:0]  wr_r, wc_r;
  logic [LINE_W-1:0] base_line_r, k_r;
  logic [COL_W-1:0]  base_col_r, l_r;
  logic [ROW_W-1:0]  res_row_r;
  logic [COL_W-1:0]  res_col_r;
  logic              rd_vld_r, rd_last_r;
  logic signed [7:0]  best_r;
  logic signed [15:0] sum_r;
  logic [15:0]        quo_r;
  logic [8:0]         rem_r;
  logic [8:0]         div_n_r;
  logic [3:0]         div_cnt_r;
  logic               neg_r;
  logic signed [7:0]  result_r;

  logic               out_vld_r;
  logic [7:0]         o_pool_r;
  logic [ROW_W-1:0]   o_row_r;
  logic [COL_W-1:0]   o_col_r;
  logic               o_last_r;

  logic [ADDR_W-1:0] raddr;
  logic              walk_last, k_last, l_last;
  logic signed [7:0] rv;
  logic [9:0]        trial;
  logic signed [16:0] q_s;

  assign k_last    = ({1'b0, k_r} == wr_r - WIN_W'(1));
  assign l_last    = (COL_W'(l_r) == COL_W'(wc_r) - COL_W'(1));
  assign walk_last = k_last && l_last;
  assign raddr     = {base_line_r + k_r, base_col_r + l_r};
  assign rv        = signed'(rdata_r);
  assign trial     = {rem_r, quo_r[15]} - {1'b0, div_n_r};
  assign q_s       = neg_r ? -signed'({1'b0, quo_r}) : signed'({1'b0, quo_r});

  assign sts.busy = (ph_r != PH_IDLE);

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[{cmd.wr_line, cmd.wr_col}] <= pixel;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE;
      rd_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= (ph_r == PH_WALK);
      rd_last_r <= walk_last;
      case (ph_r)
        PH_IDLE: if (cmd.start) begin
          ph_r <= PH_WALK;
          mode_r <= cmd.mode;
          wr_r <= cmd.win_rows;
          wc_r <= cmd.win_cols;
          base_line_r <= cmd.wr_line + LINE_W'(1) - cmd.win_rows[LINE_W-1:0];
          base_col_r <= cmd.wr_col + COL_W'(1) - COL_W'(cmd.win_cols);
          k_r <= '0;
          l_r <= '0;
          res_row_r <= cmd.res_row;
          res_col_r <= cmd.res_col;
          last_r <= cmd.res_last;
          best_r <= -8'sd128;
          sum_r <= '0;
        end
        PH_WALK: begin
          if (l_last) begin
            l_r <= '0;
            k_r <= k_r + LINE_W'(1);
          end else begin
            l_r <= l_r + COL_W'(1);
          end
          if (walk_last) ph_r <= PH_DRAIN;
        end
        PH_DRAIN: ;
        PH_DIV: begin
          quo_r <= {quo_r[14:0], ~trial[9]};
          rem_r <= trial[9] ? {rem_r[7:0], quo_r[15]} : trial[8:0];
          div_cnt_r <= div_cnt_r + 4'd1;
          if (div_cnt_r == 4'd15) ph_r <= PH_LOAD;
        end
        PH_LOAD: ;
        default: ph_r <= PH_IDLE;
      endcase
      if (rd_vld_r) begin
        if (rv > best_r) best_r <= rv;
        sum_r <= sum_r + 16'(rv);
        if (rd_last_r) begin
          if (mode_r == MODE_AVG) begin
            ph_r <= PH_DIV;
            quo_r <= ((sum_r + 16'(rv)) < 0) ? -(sum_r + 16'(rv)) : (sum_r + 16'(rv));
            neg_r <= (sum_r + 16'(rv)) < 0;
            rem_r <= '0;
            div_cnt_r <= '0;
            div_n_r <= 9'(wr_r) * 9'(wc_r);
          end else begin
            ph_r <= PH_LOAD;
            result_r <= (rv > best_r) ? rv : best_r;
          end
        end
      end
      if (ph_r == PH_LOAD && (!out_vld_r || out_tready)) begin
        out_vld_r <= 1'b1;
        o_row_r <= res_row_r;
        o_col_r <= res_col_r;
        o_last_r <= last_r;
        if (mode_r == MODE_AVG) begin
          o_pool_r <= (q_s > 17'sd127) ? 8'h7f : (q_s < -17'sd128) ? 8'h80 : q_s[7:0];
        end else begin
          o_pool_r <= result_r;
        end
        ph_r <= PH_IDLE;
      end else if (out_vld_r && out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {4'b0, o_col_r, o_row_r, o_pool_r};

endmodule

### test/int8_pooling_2d_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_pooling_2d_top_test
// Self-checking bench for the streaming int8 max/average pooling block.
// ----------------------------------------------------------------------------
// Pixels are streamed in bursts with random gaps while the result side stalls
// on its own pattern. A scoreboard keeps its own line store, counters and
// registers, predicts each pooled beat in order and compares every field.
// Directed frames cover extreme pixels, both modes, windows that would run
// past the edge, out-of-range register values, unknown indexes and a long
// output hold; random small frames follow, with mid-frame mode changes.
// ----------------------------------------------------------------------------
module int8_pooling_2d_top_test;
  import i8pool_pkg::*;

  typedef struct {
    logic [7:0] pooled;
    logic [9:0] grid_row;
    logic [9:0] grid_col;
    logic       frame_done;
  } pool_beat_t;

  class pool_scoreboard;
    logic [7:0]  line_mem [0:MAX_WINDOW*MAX_COLS-1];
    int          pix_row, pix_col, win_row, win_col;
    int          mode, img_rows, img_cols, win_h, win_w, stride;
    pool_beat_t  pending_q[$];
    int          fails;

    function new();
      mode = 0; img_rows = 1024; img_cols = 1024;
      win_h = 2; win_w = 2; stride = 2;
      restart();
      fails = 0;
    endfunction

    function void restart();
      pix_row = 0; pix_col = 0; win_row = 0; win_col = 0;
    endfunction

    function int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function int fit_count(int size, int win, int st);
      int grid, fits;
      if (size < win) return 0;
      grid = size / win;
      fits = (size - win) / st + 1;
      return (grid < fits) ? grid : fits;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_POOL_MODE:   mode = int'(val[0]);
        REG_IMAGE_ROWS:  begin img_rows = int'(val); restart(); end
        REG_IMAGE_COLS:  begin img_cols = int'(val); restart(); end
        REG_WINDOW_ROWS: begin win_h = int'(val[4:0]); restart(); end
        REG_WINDOW_COLS: begin win_w = int'(val[4:0]); restart(); end
        REG_STEP_SIZE:   begin stride = int'(val[4:0]); restart(); end
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [7:0] p);
      int rows, cols, wr, wc, st, n_i, n_j, best, sum, res, v, sr, sc;
      bit row_ends;
      pool_beat_t b;
      rows = clamp(img_rows, 1, MAX_ROWS);
      cols = clamp(img_cols, 1, MAX_COLS);
      wr = clamp(win_h, 1, MAX_WINDOW);
      wc = clamp(win_w, 1, MAX_WINDOW);
      st = clamp(stride, 1, MAX_WINDOW);
      n_i = fit_count(rows, wr, st);
      n_j = fit_count(cols, wc, st);
      row_ends = n_i > 0 && win_row < n_i && pix_row == win_row * st + wr - 1;
      line_mem[(pix_row % MAX_WINDOW) * MAX_COLS + pix_col] = p;
      if (row_ends && n_j > 0 && win_col < n_j && pix_col == win_col * st + wc - 1) begin
        best = -128;
        sum = 0;
        for (int k = 0; k < wr; k++) begin
          sr = (pix_row + 1 - wr + k) % MAX_WINDOW;
          for (int l = 0; l < wc; l++) begin
            sc = pix_col + 1 - wc + l;
            v = int'($signed(line_mem[sr * MAX_COLS + sc]));
            if (v > best) best = v;
            sum += v;
          end
        end
        if (mode == MODE_AVG) res = clamp(sum / (wr * wc), -128, 127);
        else res = best;
        b.pooled = res[7:0];
        b.grid_row = win_row[9:0];
        b.grid_col = win_col[9:0];
        b.frame_done = (win_row == n_i - 1) && (win_col == n_j - 1);
        pending_q.push_back(b);
        win_col++;
      end
      pix_col++;
      if (pix_col >= cols) begin
        pix_col = 0;
        win_col = 0;
        if (row_ends) win_row++;
        pix_row++;
        if (pix_row >= rows) restart();
      end
    endfunction

    function void check_result(logic [31:0] d, logic last);
      pool_beat_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result beat tdata=%h tlast=%b", $time, d, last);
        fails++;
        return;
      end
      e = pending_q.pop_front();
      if (d[7:0] !== e.pooled) begin
        $display("%0t: pooled exp %0d got %0d", $time, $signed(e.pooled), $signed(d[7:0]));
        fails++;
      end
      if (d[17:8] !== e.grid_row) begin
        $display("%0t: out_row exp %0d got %0d", $time, e.grid_row, d[17:8]);
        fails++;
      end
      if (d[27:18] !== e.grid_col) begin
        $display("%0t: out_col exp %0d got %0d", $time, e.grid_col, d[27:18]);
        fails++;
      end
      if (d[31:28] !== 4'd0) begin
        $display("%0t: fill bits exp 0 got %h", $time, d[31:28]);
        fails++;
      end
      if (last !== e.frame_done) begin
        $display("%0t: frame_done exp %b got %b", $time, e.frame_done, last);
        fails++;
      end
    endfunction
  endclass

  localparam int SETTLE_CYCLES = 400;
  localparam int CYCLE_LIMIT   = 3000000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = '0;    // pixel
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [31:0]      out_tdata;        // pooled, out_row, out_col, zero fill
  logic             out_tlast;        // frame_done

  pool_scoreboard sb = new();
  int cycles = 0;
  int hold_cycles = 0;
  int burst_left = 0;
  int rand_items = 0;

  int8_pooling_2d_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("int8_pooling_2d_top test failed");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);

  // receiver: random ready pattern, changing density, plus requested long holds
  initial begin
    int ready_pct;
    ready_pct = 100;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end else begin
        if ($urandom_range(0, 199) == 0) begin
          case ($urandom_range(0, 3))
            0: ready_pct = 100;
            1: ready_pct = 75;
            2: ready_pct = 40;
            default: ready_pct = 10;
          endcase
        end
        out_tready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  task automatic cfg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_geometry(int m, int rows, int cols, int wr, int wc, int st);
    cfg_write(REG_POOL_MODE, CFG_W'(m));
    cfg_write(REG_IMAGE_ROWS, CFG_W'(rows));
    cfg_write(REG_IMAGE_COLS, CFG_W'(cols));
    cfg_write(REG_WINDOW_ROWS, CFG_W'(wr));
    cfg_write(REG_WINDOW_COLS, CFG_W'(wc));
    cfg_write(REG_STEP_SIZE, CFG_W'(st));
  endtask

  task automatic send_pixel(logic [7:0] p);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= p;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(p);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      if ($urandom_range(0, 2) != 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 8'h80;
      1: return 8'h7f;
      2: return 8'h00;
      3: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_frames(int n, bit rnd);
    for (int i = 0; i < n; i++) begin
      send_pixel(rnd ? rand_pixel() : 8'($urandom_range(0, 255)));
      if (rnd) rand_items++;
    end
  endtask

  initial begin
    int rows, cols, n;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // extremes in a 4x4 frame, both modes
    set_geometry(MODE_MAX, 4, 4, 2, 2, 2);
    send_pixel(8'h80); send_pixel(8'h80); send_pixel(8'h7f); send_pixel(8'h00);
    send_pixel(8'h80); send_pixel(8'h80); send_pixel(8'hff); send_pixel(8'h01);
    send_pixel(8'h7f); send_pixel(8'h7f); send_pixel(8'h80); send_pixel(8'hff);
    send_pixel(8'h7f); send_pixel(8'h7e); send_pixel(8'h55); send_pixel(8'haa);
    drain();
    cfg_write(REG_POOL_MODE, CFG_W'(MODE_AVG));
    send_pixel(8'h80); send_pixel(8'h80); send_pixel(8'hff); send_pixel(8'hff);
    send_pixel(8'h80); send_pixel(8'h80); send_pixel(8'hfe); send_pixel(8'h00);
    drain();
    // unknown indexes are ignored
    cfg_write(3'd6, '1);
    cfg_write(3'd7, 11'h2aa);
    send_frames(8, 0);
    drain();

    // stride above the window: edge windows dropped
    set_geometry(MODE_MAX, 6, 7, 2, 3, 3);
    send_frames(42, 0);
    drain();
    set_geometry(MODE_AVG, 7, 8, 1, 2, 5);
    send_frames(56, 0);
    drain();
    // window taller than the image: no results
    set_geometry(MODE_MAX, 3, 3, 4, 2, 1);
    send_frames(9, 0);
    drain();
    // zero writes saturate to one: every pixel is its own frame
    set_geometry(MODE_MAX, 0, 0, 0, 0, 0);
    send_frames(6, 0);
    drain();
    // oversize window height, width and stride saturate to 16
    set_geometry(MODE_AVG, 16, 1, 31, 1, 31);
    for (int i = 0; i < 16; i++) send_pixel(8'h80);
    drain();
    set_geometry(MODE_AVG, 1, 16, 1, 31, 1);
    send_frames(16, 0);
    drain();
    set_geometry(MODE_MAX, 1, 20, 1, 1, 31);
    send_frames(20, 0);
    drain();
    // widest and tallest images, oversize sizes saturate
    set_geometry(MODE_AVG, 1, 2047, 1, 16, 16);
    send_frames(32, 0);
    drain();
    set_geometry(MODE_MAX, 2047, 1, 16, 1, 16);
    send_frames(32, 0);
    drain();

    // long output hold so the result register fills and input stalls
    set_geometry(MODE_MAX, 8, 8, 1, 1, 1);
    hold_cycles = 1500;
    send_frames(64, 1);
    drain();

    while (rand_items < 190) begin
      rows = $urandom_range(1, 12);
      cols = $urandom_range(1, 12);
      set_geometry($urandom_range(0, 1), rows, cols, $urandom_range(1, 4),
                   $urandom_range(1, 4), $urandom_range(1, 5));
      n = rows * cols * $urandom_range(1, 3);
      if ($urandom_range(0, 3) == 0) begin
        send_frames(n / 2, 1);
        drain();
        cfg_write(REG_POOL_MODE, CFG_W'($urandom_range(0, 1)));
        send_frames(n - n / 2, 1);
      end else begin
        send_frames(n, 1);
      end
      if ($urandom_range(0, 4) == 0) send_frames($urandom_range(1, 10), 1);
      drain();
    end

    if (sb.fails == 0) begin
      $display("int8_pooling_2d_top test passed");
    end else begin
      $display("int8_pooling_2d_top test failed");
    end
    $finish;
  end

endmodule
